[hw/rtl/relative_path_normalizer_unit_assert.svh]
// Assertion macros for the path normaliser; empty bodies under synthesis.
`ifndef RELATIVE_PATH_NORMALIZER_UNIT_ASSERT_SVH
`define RELATIVE_PATH_NORMALIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define RPN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rpn: assertion failed");
// Next-cycle implication
`define RPN_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rpn: assertion failed");
`else
`define RPN_ASSERT_IMP(lbl, ante, cons)
`define RPN_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/rpn_pkg.sv]
// Shared types and constants of the relative path normaliser.
`default_nettype none
package rpn_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_TOO_LONG = 2'd2,
		ST_ESCAPE   = 2'd3
	} rpn_status_t;

	// Characters of interest
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	// Input transaction
	typedef struct packed {
		logic [7:0] path_char;
		logic       end_of_path;
		logic       empty_path;
	} rpn_in_t;

	// Result transaction
	typedef struct packed {
		logic [7:0] out_char;
		logic [1:0] status;
		logic       last_out;
	} rpn_out_t;

	// Sequencer to scan unit controls
	typedef struct packed {
		logic clear;    // start of a new scan
		logic byte_vld; // a path byte is presented
		logic fin;      // close the final segment
	} rpn_scan_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/rpn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rpn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hw/rtl/rpn_scan.sv]
// Segment scan unit: one path byte per step, builds the output and segment stack.
`default_nettype none
module rpn_scan #(
	parameter int MAX_IN = 64,
	parameter int PW     = $clog2(MAX_IN + 2),
	parameter int AW_O   = $clog2(MAX_IN + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rpn_pkg::rpn_scan_ctl_t ctl,
	input  wire logic [7:0]            ch,
	output rpn_pkg::rpn_status_t       err,
	output logic [PW-1:0]              wptr,
	output logic                       ow_we,
	output logic [AW_O-1:0]            ow_addr,
	output logic [7:0]                 ow_data
);
	import rpn_pkg::*;

	localparam int STACK_SIZE = MAX_IN / 2 + 1;
	localparam int SAW        = $clog2(STACK_SIZE);
	localparam int DW         = $clog2(STACK_SIZE + 1);

	logic [PW-1:0] wptr_q;
	logic [PW-1:0] seg_start_q;
	logic [1:0]    seg_len_q;   // saturates at 3
	logic          dot0_q;
	logic          dot1_q;
	logic [DW-1:0] depth_q;
	rpn_status_t   err_q;

	logic          active;
	logic          is_bs;
	logic          is_chr;
	logic          seg_end;
	logic          seg_drop;
	logic          seg_up;
	logic          push;
	logic [DW-1:0] depth_m1;
	logic [PW-1:0] top_rdata;
	logic [PW-1:0] wptr_p1;

	// Byte classification and segment decisions
	always_comb begin
		active   = (err_q == ST_OK);
		is_bs    = ctl.byte_vld && (ch == CH_BSLASH);
		is_chr   = ctl.byte_vld && (ch != CH_BSLASH) && (ch != CH_SLASH);
		seg_end  = active && (ctl.fin || (ctl.byte_vld && (ch == CH_SLASH)));
		seg_drop = (seg_len_q == 2'd0) || ((seg_len_q == 2'd1) && dot0_q);
		seg_up   = (seg_len_q == 2'd2) && dot0_q && dot1_q;
		push     = seg_end && !seg_drop && !seg_up;
		depth_m1 = depth_q - DW'(1);
		wptr_p1  = wptr_q + PW'(1);
	end

	// Output buffer write: segment bytes, then a trailing '/' for each kept segment
	assign ow_we   = active && (is_chr || push);
	assign ow_addr = wptr_q[AW_O-1:0];
	assign ow_data = push ? CH_SLASH : ch;

	// Stack of output offsets of kept segments; top is read continuously
	rpn_ram #(
		.WIDTH (PW),
		.DEPTH (STACK_SIZE)
	) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (depth_q[SAW-1:0]),
		.wdata (seg_start_q),
		.raddr (depth_m1[SAW-1:0]),
		.rdata (top_rdata)
	);

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			seg_start_q <= '0;
			seg_len_q   <= '0;
			dot0_q      <= 1'b0;
			dot1_q      <= 1'b0;
			depth_q     <= '0;
			err_q       <= ST_OK;
		end else if (ctl.clear) begin
			wptr_q      <= '0;
			seg_start_q <= '0;
			seg_len_q   <= '0;
			dot0_q      <= 1'b0;
			dot1_q      <= 1'b0;
			depth_q     <= '0;
			err_q       <= ST_OK;
		end else if (active) begin
			if (is_bs) begin
				err_q <= ST_INVALID;
			end else if (seg_end) begin
				if (seg_drop) begin
					// empty or "." segment: discard its bytes
					wptr_q <= seg_start_q;
				end else if (seg_up) begin
					// ".." segment: back to the previous kept segment
					if (depth_q == '0) begin
						err_q <= ST_ESCAPE;
					end else begin
						wptr_q      <= top_rdata;
						seg_start_q <= top_rdata;
						depth_q     <= depth_m1;
					end
				end else begin
					wptr_q      <= wptr_p1;
					seg_start_q <= wptr_p1;
					depth_q     <= depth_q + DW'(1);
				end
				seg_len_q <= '0;
				dot0_q    <= 1'b0;
				dot1_q    <= 1'b0;
			end else if (is_chr) begin
				wptr_q <= wptr_p1;
				if (seg_len_q != 2'd3) begin
					seg_len_q <= seg_len_q + 2'd1;
				end
				if (seg_len_q == 2'd0) begin
					dot0_q <= (ch == CH_DOT);
				end
				if (seg_len_q == 2'd1) begin
					dot1_q <= (ch == CH_DOT);
				end
			end
		end
	end

	assign err  = err_q;
	assign wptr = wptr_q;

endmodule
`default_nettype wire

[hw/rtl/relative_path_normalizer_unit.sv]
// Flow: bytes load one per cycle while busy is low; after the final byte come S_CHECK,
// S_SCAN, S_DRAIN, S_FIN, S_DONE and S_EMIT, one result byte per cycle. An error result is
// registered out of S_CHECK (length or prefix) or S_DONE (scan, empty, too long).
// busy stays high from the final byte to the last issue; the receiver cannot stall.
// Throughput is set by the single scan unit stepping one stored byte per cycle.
// Reset: async active low clears sequencer and counters; buffers keep contents.
`default_nettype none
`include "relative_path_normalizer_unit_assert.svh"
module relative_path_normalizer_unit #(
	parameter int MAX_INPUT_LENGTH  = 64,
	parameter int MAX_OUTPUT_LENGTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire rpn_pkg::rpn_in_t item,
	output logic                  strobe,
	output rpn_pkg::rpn_out_t     result
);
	import rpn_pkg::*;

	localparam int AW_I = $clog2(MAX_INPUT_LENGTH);
	localparam int LW   = $clog2(MAX_INPUT_LENGTH + 1);
	localparam int PW   = $clog2(MAX_INPUT_LENGTH + 2);
	localparam logic [31:0] OUT_LIM = 32'(MAX_OUTPUT_LENGTH + 1);

	typedef enum logic [6:0] {
		S_LOAD  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_FIN   = 7'b0010000,
		S_DONE  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t        state_q, state_d;
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic [7:0]    b0_q;
	logic [7:0]    b1_q;
	logic [AW_I-1:0] rd_idx_q;
	logic          rd_vld_s1;
	logic [LW-1:0] em_idx_q;
	logic [LW-1:0] em_last_idx_q;
	logic          em_vld_s1;
	logic          em_last_s1;
	logic          err_vld_q;
	rpn_status_t   err_st_q;

	logic          acc;
	logic          in_we;
	logic          path_end;
	logic          path_clr;
	logic          err_set;
	rpn_status_t   err_st_d;
	logic [LW-1:0] len_m1;
	logic          scan_last;
	logic          em_last;
	logic [7:0]    in_rdata;
	logic [7:0]    out_rdata;
	rpn_scan_ctl_t scan_ctl;
	rpn_status_t   scan_err;
	logic [PW-1:0] scan_wptr;
	logic [PW-1:0] wptr_m2;
	logic [31:0]   wptr_ext;
	logic          ow_we;
	logic [LW-1:0] ow_addr;
	logic [7:0]    ow_data;

	// Handshake and load decode
	always_comb begin
		busy      = (state_q != S_LOAD);
		acc       = start && (state_q == S_LOAD);
		in_we     = acc && !item.empty_path && (len_q < LW'(MAX_INPUT_LENGTH));
		path_end  = acc && (item.end_of_path || item.empty_path);
		len_m1    = len_q - LW'(1);
		scan_last = (rd_idx_q == len_m1[AW_I-1:0]);
		em_last   = (em_idx_q == em_last_idx_q);
		wptr_m2   = scan_wptr - PW'(2);
		wptr_ext  = 32'(scan_wptr);
	end

	// Sequencer
	always_comb begin
		state_d  = state_q;
		err_set  = 1'b0;
		err_st_d = ST_OK;
		path_clr = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				if (path_end) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				// length and absolute-path checks, in priority order
				if (ovf_q) begin
					err_set  = 1'b1;
					err_st_d = ST_TOO_LONG;
				end else if (len_q == '0) begin
					err_set  = 1'b1;
					err_st_d = ST_INVALID;
				end else if ((b0_q == CH_SLASH) || (b0_q == CH_BSLASH)) begin
					err_set  = 1'b1;
					err_st_d = ST_INVALID;
				end else if ((len_q >= LW'(2)) && (b1_q == CH_COLON)) begin
					err_set  = 1'b1;
					err_st_d = ST_INVALID;
				end
				if (err_set) begin
					path_clr = 1'b1;
					state_d  = S_LOAD;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				// scan error, then empty result, then output length
				if (scan_err != ST_OK) begin
					err_set  = 1'b1;
					err_st_d = scan_err;
				end else if (wptr_ext < 32'd2) begin
					err_set  = 1'b1;
					err_st_d = ST_INVALID;
				end else if (wptr_ext > OUT_LIM) begin
					err_set  = 1'b1;
					err_st_d = ST_TOO_LONG;
				end
				if (err_set) begin
					path_clr = 1'b1;
					state_d  = S_LOAD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (em_last) begin
					path_clr = 1'b1;
					state_d  = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			len_q      <= '0;
			ovf_q      <= 1'b0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			em_idx_q   <= '0;
			em_vld_s1  <= 1'b0;
			em_last_s1 <= 1'b0;
			err_vld_q  <= 1'b0;
			err_st_q   <= ST_OK;
		end else begin
			state_q    <= state_d;
			rd_vld_s1  <= (state_q == S_SCAN);
			em_vld_s1  <= (state_q == S_EMIT);
			em_last_s1 <= (state_q == S_EMIT) && em_last;
			err_vld_q  <= err_set;
			if (err_set) begin
				err_st_q <= err_st_d;
			end
			// byte count and overflow of the path being loaded
			if (path_clr) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (in_we) begin
				len_q <= len_q + LW'(1);
			end else if (acc && !item.empty_path) begin
				ovf_q <= 1'b1;
			end
			// scan read pointer
			if (state_q == S_CHECK) begin
				rd_idx_q <= '0;
			end else if (state_q == S_SCAN) begin
				rd_idx_q <= rd_idx_q + AW_I'(1);
			end
			// emit read pointer
			if (state_q == S_DONE) begin
				em_idx_q <= '0;
			end else if (state_q == S_EMIT) begin
				em_idx_q <= em_idx_q + LW'(1);
			end
		end
	end

	// Payload registers: first two bytes, final emit index
	always_ff @(posedge clk) begin
		if (in_we && (len_q == LW'(0))) begin
			b0_q <= item.path_char;
		end
		if (in_we && (len_q == LW'(1))) begin
			b1_q <= item.path_char;
		end
		if (state_q == S_DONE) begin
			em_last_idx_q <= wptr_m2[LW-1:0];
		end
	end

	// Input byte store
	rpn_ram #(
		.WIDTH (8),
		.DEPTH (MAX_INPUT_LENGTH)
	) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (len_q[AW_I-1:0]),
		.wdata (item.path_char),
		.raddr (rd_idx_q),
		.rdata (in_rdata)
	);

	// Scan unit
	always_comb begin
		scan_ctl.clear    = (state_q == S_CHECK);
		scan_ctl.byte_vld = rd_vld_s1;
		scan_ctl.fin      = (state_q == S_FIN);
	end

	rpn_scan #(
		.MAX_IN (MAX_INPUT_LENGTH),
		.PW     (PW),
		.AW_O   (LW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.ch      (in_rdata),
		.err     (scan_err),
		.wptr    (scan_wptr),
		.ow_we   (ow_we),
		.ow_addr (ow_addr),
		.ow_data (ow_data)
	);

	// Normalised output store, one spare entry for the trailing separator
	rpn_ram #(
		.WIDTH (8),
		.DEPTH (MAX_INPUT_LENGTH + 1)
	) u_out_ram (
		.clk   (clk),
		.we    (ow_we),
		.waddr (ow_addr),
		.wdata (ow_data),
		.raddr (em_idx_q),
		.rdata (out_rdata)
	);

	// Result port: emitted byte or single error transaction
	always_comb begin
		strobe = em_vld_s1 || err_vld_q;
		if (em_vld_s1) begin
			result.out_char = out_rdata;
			result.status   = ST_OK;
			result.last_out = em_last_s1;
		end else begin
			result.out_char = 8'd0;
			result.status   = err_st_q;
			result.last_out = 1'b1;
		end
	end

	// Checks
	`RPN_ASSERT_IMP(a_fin_no_byte, state_q == S_FIN, !rd_vld_s1)
	`RPN_ASSERT_IMP(a_one_source, em_vld_s1, !err_vld_q)
	`RPN_ASSERT_NXT(a_last_ends_emit, em_vld_s1 && em_last_s1, !em_vld_s1)
	`RPN_ASSERT_IMP(a_err_is_last, strobe && (result.status != ST_OK), result.last_out)

endmodule
`default_nettype wire
